// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// All properties sample on the rising edge of aclk and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define SHFC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SHFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/shfc_pkg.sv =====
// ----------------------------------------------------------------------------
// shfc_pkg
// Types and constants of the sample-and-hold flow counter.
// ----------------------------------------------------------------------------
`default_nettype none

package shfc_pkg;

    localparam logic [9:0]  PERMILLE_FULL  = 10'd1000;
    localparam logic [9:0]  PERMILLE_RESET = 10'd1;
    localparam logic [31:0] OUT_CNT_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        mode;         // 0 = update, 1 = readout
        logic [31:0] flow_key;
        logic [9:0]  random_draw;
        logic [5:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic        was_hit;
        logic        was_inserted;
        logic        dropped_full;
        logic        entry_valid;
        logic [31:0] entry_key;
        logic [31:0] entry_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic issue_scan;  // read table at the scan pointer
        logic issue_slot;  // read table at the readout slot
        logic emit_hit;
        logic emit_miss;
        logic emit_read;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_mode;     // mode of the item on the input channel
        logic scan_more;   // scan pointer still below the fill count
        logic cmp_hit;     // last read slot matches the key
        logic out_free;    // output register can take a result
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/sample_and_hold_flow_counter_top.sv =====
// ----------------------------------------------------------------------------
// sample_and_hold_flow_counter_top
// Sample-and-hold heavy-hitter table with saturating per-key counts.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_data: mode 0 updates the table with
// flow_key (hit -> count+1, miss -> inserted with count one if random_draw is
// below sample_permille (1000 and up samples everything) and a slot is free;
// mode 1 reads table slot read_slot. Output channel m_valid/m_ready/m_data
// returns one result item per input item, in order. cfg_we/cfg_wdata write
// sample_permille; write it only while the block is idle.
// Timing: items are handled one at a time. A readout issues the slot read,
// then loads its result. An update scans the occupied slots through the key
// table's single read port, one slot per cycle, comparing each slot while
// the next is read; a hit ends the scan, a miss is found once every occupied
// slot has been compared. The next item is accepted the cycle after the
// result is loaded into the output register, so a stalled receiver holds at
// most one result while one more item is taken; further work waits until the
// output register drains. Reset (aresetn low, synchronous) empties the table
// through its fill count, sets sample_permille to 1 and clears output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_and_hold_flow_counter_top #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 32,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire shfc_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output shfc_pkg::out_item_t     m_data,
    input  wire logic               cfg_we,
    input  wire logic [9:0]         cfg_wdata
);

    shfc_pkg::dp_cmd_t cmd;
    shfc_pkg::dp_sts_t sts;

    shfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    shfc_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== sv/shfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// shfc_ctrl
// Sequencer: accepts an item, steps the table scan, emits one result.
// ----------------------------------------------------------------------------
`default_nettype none

module shfc_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire shfc_pkg::dp_sts_t sts,
    output shfc_pkg::dp_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_RDREQ = 6'b000100,
        ST_RDOUT = 6'b001000,
        ST_HIT   = 6'b010000,
        ST_MISS  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.in_mode ? ST_RDREQ : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // compare of the previous read overlaps the next read
                if (sts.cmp_hit) begin
                    state_next = ST_HIT;
                end else if (sts.scan_more) begin
                    cmd.issue_scan = 1'b1;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_RDREQ: begin
                cmd.issue_slot = 1'b1;
                state_next     = ST_RDOUT;
            end
            ST_RDOUT: begin
                if (sts.out_free) begin
                    cmd.emit_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_HIT: begin
                if (sts.out_free) begin
                    cmd.emit_hit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (sts.out_free) begin
                    cmd.emit_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/shfc_dpath.sv =====
// ----------------------------------------------------------------------------
// shfc_dpath
// Key and count tables, scan pointer, fill count, threshold register and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shfc_dpath #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 32,
    parameter int COUNT_BITS    = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire shfc_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output shfc_pkg::out_item_t     m_data,
    input  wire logic               cfg_we,
    input  wire logic [9:0]         cfg_wdata,
    input  wire shfc_pkg::dp_cmd_t  cmd,
    output shfc_pkg::dp_sts_t       sts
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int USE_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SLT_W = (USE_W > 6) ? USE_W : 6;
    localparam int OUT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    // tables: no reset, entries at or above the fill count are never read out
    logic [KEY_BITS-1:0]   key_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] cnt_mem [TABLE_ENTRIES];

    logic [9:0]            permille_reg;
    logic [USE_W-1:0]      used_reg, used_next;
    logic [USE_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic [KEY_BITS-1:0]   key_rd_reg;
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    logic [KEY_BITS-1:0]   item_key_reg;
    logic [9:0]            item_draw_reg;
    logic [5:0]            item_slot_reg;

    logic                  m_valid_reg, m_valid_next;
    shfc_pkg::out_item_t   m_data_reg, m_data_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      ins_addr;
    logic                  sampled;
    logic                  full;
    logic                  insert;
    logic                  slot_ok;
    logic                  push;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;

    function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
        logic [OUT_W-1:0] e;
        e = OUT_W'(v);
        clip32 = (e > OUT_W'(shfc_pkg::OUT_CNT_MAX)) ? shfc_pkg::OUT_CNT_MAX : e[31:0];
    endfunction

    // ---- status ----
    assign sts.in_mode   = s_data.mode;
    assign sts.scan_more = (scan_idx_reg < used_reg);
    assign sts.cmp_hit   = cmp_vld_reg && (key_rd_reg == item_key_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;

    // ---- decisions ----
    assign sampled = (permille_reg >= shfc_pkg::PERMILLE_FULL) || (item_draw_reg < permille_reg);
    assign full    = (used_reg == USE_W'(TABLE_ENTRIES));
    assign insert  = cmd.emit_miss && sampled && !full;
    assign slot_ok = (SLT_W'(item_slot_reg) < SLT_W'(used_reg));
    assign cnt_inc = (cnt_rd_reg == '1) ? cnt_rd_reg : cnt_rd_reg + COUNT_BITS'(1);

    assign rd_en    = cmd.issue_scan || cmd.issue_slot;
    assign rd_addr  = cmd.issue_slot ? IDX_W'(item_slot_reg) : scan_idx_reg[IDX_W-1:0];
    assign ins_addr = used_reg[IDX_W-1:0];

    assign cnt_we    = cmd.emit_hit || insert;
    assign cnt_waddr = cmd.emit_hit ? cmp_idx_reg : ins_addr;
    assign cnt_wdata = cmd.emit_hit ? cnt_inc : COUNT_BITS'(1);

    // ---- table memories ----
    always_ff @(posedge aclk) begin
        if (insert) begin
            key_mem[ins_addr] <= item_key_reg;
        end
        if (rd_en) begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (rd_en) begin
            cnt_rd_reg <= cnt_mem[rd_addr];
        end
    end

    // ---- item capture ----
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_key_reg  <= KEY_BITS'(s_data.flow_key);
            item_draw_reg <= s_data.random_draw;
            item_slot_reg <= s_data.read_slot;
        end
        if (rd_en) begin
            cmp_idx_reg <= rd_addr;
        end
    end

    // ---- control registers ----
    always_comb begin
        used_next = used_reg;
        if (insert) begin
            used_next = used_reg + USE_W'(1);
        end
        scan_idx_next = scan_idx_reg;
        if (cmd.load) begin
            scan_idx_next = '0;
        end else if (cmd.issue_scan) begin
            scan_idx_next = scan_idx_reg + USE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            permille_reg <= shfc_pkg::PERMILLE_RESET;
            used_reg     <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                permille_reg <= cfg_wdata;
            end
            used_reg     <= used_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmd.issue_scan;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ---- result formation and output register ----
    assign push = cmd.emit_hit || cmd.emit_miss || cmd.emit_read;

    always_comb begin
        m_data_next = '0;
        if (cmd.emit_hit) begin
            m_data_next.was_hit     = 1'b1;
            m_data_next.entry_valid = 1'b1;
            m_data_next.entry_key   = 32'(item_key_reg);
            m_data_next.entry_count = clip32(cnt_inc);
        end else if (cmd.emit_miss) begin
            m_data_next.was_inserted = insert;
            m_data_next.dropped_full = sampled && full;
            m_data_next.entry_valid  = insert;
            m_data_next.entry_key    = 32'(item_key_reg);
            m_data_next.entry_count  = insert ? 32'd1 : 32'd0;
        end else if (slot_ok) begin
            m_data_next.entry_valid = 1'b1;
            m_data_next.entry_key   = 32'(key_rd_reg);
            m_data_next.entry_count = clip32(cnt_rd_reg);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== sv/shfc_checker.sv =====
// ----------------------------------------------------------------------------
// shfc_checker
// Port-level checks of the flow counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module shfc_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire shfc_pkg::out_item_t m_data
);

    logic out_stall;
    logic out_counted;
    logic out_drop;
    logic out_ins;
    logic out_hit;
    logic drop_clean;
    logic ins_one;

    assign out_stall   = m_valid && !m_ready;
    assign out_counted = m_valid && (m_data.was_hit || m_data.was_inserted);
    assign out_drop    = m_valid && m_data.dropped_full;
    assign out_ins     = m_valid && m_data.was_inserted;
    assign out_hit     = m_valid && m_data.was_hit;
    assign drop_clean  = !m_data.entry_valid && (m_data.entry_count == 32'd0)
                         && !m_data.was_inserted;
    assign ins_one     = (m_data.entry_count == 32'd1) && !m_data.was_hit;

    `SHFC_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_data), "stalled result changed")

    `SHFC_ASSERT_SAME(a_count_valid, out_counted, m_data.entry_valid, "hit or insert without entry")

    `SHFC_ASSERT_SAME(a_drop_empty, out_drop, drop_clean, "dropped item carries an entry")

    `SHFC_ASSERT_SAME(a_insert_one, out_ins, ins_one, "inserted entry count is not one")

    `SHFC_ASSERT_SAME(a_hit_nonzero, out_hit, m_data.entry_count != 32'd0, "hit with zero count")

endmodule

bind sample_and_hold_flow_counter_top shfc_checker u_shfc_checker (.*);

`default_nettype wire

// ===== tb/sample_and_hold_flow_counter_top_tb.sv =====
// ----------------------------------------------------------------------------
// sample_and_hold_flow_counter_top_tb
// Self-checking bench for the sample-and-hold flow counter.
// ----------------------------------------------------------------------------
// Keeps its own copy of the flow table. Each accepted item updates that copy
// and queues the result it should produce; every result leaving the block is
// checked field by field against the oldest queued result. Directed items
// cover the sampling boundaries, then random traffic fills the table, runs
// into drops and goes through several thresholds. The sender works in bursts,
// the receiver stalls on its own pattern, and once holds off long enough for
// the block to stall its input.
// ----------------------------------------------------------------------------

module sample_and_hold_flow_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   TABLE_SLOTS    = 64;
    localparam logic MODE_UPDATE    = 1'b0;
    localparam logic MODE_READ      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   DRAIN_CYCLES   = 80;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    shfc_pkg::in_item_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    shfc_pkg::out_item_t m_data;
    logic                cfg_we    = 1'b0;
    logic [9:0]          cfg_wdata = '0;

    // predicted table contents
    logic [31:0] tbl_key   [TABLE_SLOTS];
    logic [31:0] tbl_count [TABLE_SLOTS];
    bit          tbl_used  [TABLE_SLOTS];
    int          fill_level     = 0;
    logic [9:0]  permille_model = shfc_pkg::PERMILLE_RESET;

    shfc_pkg::out_item_t pending_results[$];
    int          mismatches     = 0;
    int          stalled_cycles = 0;
    int          burst_left     = 0;
    bit          hold_req       = 1'b0;

    sample_and_hold_flow_counter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------------
    function automatic shfc_pkg::out_item_t track_flow(input shfc_pkg::in_item_t item);
        shfc_pkg::out_item_t res;
        int                  i;
        res = '0;
        if (item.mode == MODE_READ) begin
            if (item.read_slot < TABLE_SLOTS && tbl_used[item.read_slot]) begin
                res.entry_valid = 1'b1;
                res.entry_key   = tbl_key[item.read_slot];
                res.entry_count = tbl_count[item.read_slot];
            end
            return res;
        end
        res.entry_key = item.flow_key;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (tbl_used[i] && tbl_key[i] == item.flow_key) begin
                if (tbl_count[i] != shfc_pkg::OUT_CNT_MAX)
                    tbl_count[i] = tbl_count[i] + 1;
                res.was_hit     = 1'b1;
                res.entry_valid = 1'b1;
                res.entry_count = tbl_count[i];
                return res;
            end
        end
        // not sampled: all flags low, count zero
        if (!(permille_model >= shfc_pkg::PERMILLE_FULL
              || item.random_draw < permille_model))
            return res;
        for (i = 0; i < TABLE_SLOTS; i++) begin
            if (!tbl_used[i]) begin
                tbl_used[i]      = 1'b1;
                tbl_key[i]       = item.flow_key;
                tbl_count[i]     = 32'd1;
                fill_level++;
                res.was_inserted = 1'b1;
                res.entry_valid  = 1'b1;
                res.entry_count  = 32'd1;
                return res;
            end
        end
        res.dropped_full = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic shfc_pkg::in_item_t make_update(input logic [31:0] key,
                                                       input logic [9:0]  draw);
        shfc_pkg::in_item_t item;
        item.mode        = MODE_UPDATE;
        item.flow_key    = key;
        item.random_draw = draw;
        item.read_slot   = 6'($urandom);
        return item;
    endfunction

    function automatic shfc_pkg::in_item_t make_read(input logic [5:0] slot);
        shfc_pkg::in_item_t item;
        item.mode        = MODE_READ;
        item.flow_key    = $urandom;
        item.random_draw = 10'($urandom);
        item.read_slot   = slot;
        return item;
    endfunction

    // Reads go to any slot; empty slots read back as zero.
    function automatic shfc_pkg::in_item_t pick_item(input int hit_pct, input int read_pct);
        int         roll;
        logic [9:0] draw;
        roll = $urandom_range(0, 99);
        draw = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(0, 999));
        if (roll < read_pct)
            return make_read(6'($urandom_range(0, TABLE_SLOTS - 1)));
        if (fill_level > 0 && roll < read_pct + hit_pct)
            return make_update(tbl_key[$urandom_range(0, fill_level - 1)], draw);
        return make_update($urandom, draw);
    endfunction

    // ------------------------------------------------------------------------
    // Sender, config writes, idle wait
    // ------------------------------------------------------------------------
    task automatic send_item(input shfc_pkg::in_item_t item);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(track_flow(item));
    endtask

    task automatic wait_idle();
        burst_left = 0;
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_permille(input logic [9:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        permille_model = value;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // threshold 1 out of reset: only draw 0 samples
    task automatic test_reset_defaults();
        send_item(make_update(32'h1234_5678, 10'd1));
        send_item(make_update(32'h1234_5678, 10'd0));
        send_item(make_update(32'h1234_5678, 10'd999));
        send_item(make_read(6'd0));
        send_item(make_update(32'h0000_0000, 10'd1023));
        wait_idle();
    endtask

    task automatic test_exact_count();
        write_permille(shfc_pkg::PERMILLE_FULL);
        send_item(make_update(32'h0000_0000, 10'd1023));
        send_item(make_update(32'hFFFF_FFFF, 10'd999));
        send_item(make_update(32'h0000_0000, 10'd500));
        send_item(make_update(32'h0000_0000, 10'd0));
        send_item(make_read(6'd0));
        send_item(make_read(6'd1));
        send_item(make_read(6'd2));
        send_item(make_update(32'hA5A5_A5A5, 10'd0));
        wait_idle();
    endtask

    // threshold 0: unseen keys never enter, held keys still count
    task automatic test_no_sampling();
        write_permille(10'd0);
        send_item(make_update(32'h5A5A_5A5A, 10'd0));
        send_item(make_update(32'hFFFF_FFFF, 10'd1023));
        send_item(make_update(32'h7FFF_FFFF, 10'd1023));
        wait_idle();
    endtask

    task automatic test_sampled_mix();
        write_permille(10'd500);
        repeat (70) send_item(pick_item(45, 20));
        write_permille(10'($urandom_range(1, 999)));
        repeat (70) send_item(pick_item(45, 20));
        wait_idle();
    endtask

    // everything samples until the table is full, then new keys drop
    task automatic test_fill_and_drop();
        write_permille(10'h3FF);
        while (fill_level < TABLE_SLOTS) send_item(pick_item(20, 10));
        send_item(make_read(6'd63));
        send_item(make_update(tbl_key[TABLE_SLOTS - 1], 10'd0));
        repeat (60) send_item(pick_item(40, 25));
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (16) send_item(pick_item(40, 20));
        wait_idle();
    endtask

    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       write_permille(10'd0);
                1:       write_permille(shfc_pkg::PERMILLE_FULL);
                2:       write_permille(10'($urandom_range(0, 1023)));
                default: write_permille(10'($urandom_range(1, 999)));
            endcase
            repeat (30) send_item(pick_item(35, 25));
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall pattern refreshed when its 16-bit word is used up, plus one long hold
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] stall_word;
        int          bit_idx;
        stall_word = '0;
        bit_idx    = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (bit_idx == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_word = '0;
                        1:       stall_word = 16'($urandom);
                        default: stall_word = 16'($urandom & $urandom);
                    endcase
                end
                m_ready <= !stall_word[bit_idx];
                bit_idx = (bit_idx + 1) % 16;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        shfc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %p",
                         $time, m_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("was_hit",      32'(want.was_hit),      32'(m_data.was_hit));
                check_field("was_inserted", 32'(want.was_inserted), 32'(m_data.was_inserted));
                check_field("dropped_full", 32'(want.dropped_full), 32'(m_data.dropped_full));
                check_field("entry_valid",  32'(want.entry_valid),  32'(m_data.entry_valid));
                check_field("entry_key",    want.entry_key,         m_data.entry_key);
                check_field("entry_count",  want.entry_count,       m_data.entry_count);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("sample_and_hold_flow_counter_top_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_exact_count();
        test_no_sampling();
        test_sampled_mix();
        test_fill_and_drop();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("sample_and_hold_flow_counter_top_tb passed");
        end else begin
            $display("sample_and_hold_flow_counter_top_tb failed");
        end
        $finish;
    end

endmodule
